@@ sv/assert_macros.svh @@
// assertion macros shared by the ranging filter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled on aclk, off while in reset
`define URMF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// same-cycle implication sampled on aclk, off while in reset
`define URMF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/urmf_pkg.sv @@
// types and constants for the ultrasonic ranging median filter
`timescale 1ns / 1ps

package urmf_pkg;

    // median window
    localparam int WIN_SIZE = 5;
    localparam int MED_RANK = WIN_SIZE / 2;
    localparam int SLOT_W   = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1;
    localparam int RANK_W   = $clog2(WIN_SIZE + 1);

    // field widths
    localparam int DIST_W  = 18;
    localparam int TICK_W  = 16;
    localparam int CNT_W   = 20;
    localparam int TW_W    = 10;
    localparam int GAP_W   = 20;
    localparam int SCALE_W = 18;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = TICK_W + SCALE_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // front to back queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // register reset values
    localparam logic [TW_W-1:0]    TRIGGER_WIDTH_RST  = TW_W'(10);
    localparam logic [TICK_W-1:0]  ECHO_TIMEOUT_RST   = TICK_W'(50000);
    localparam logic [GAP_W-1:0]   REPEAT_GAP_RST     = GAP_W'(100000);
    localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RST = SCALE_W'(111411);

    typedef enum logic [1:0] {
        PH_TRIG,
        PH_WAIT,
        PH_HIGH,
        PH_GAP
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_WIDTH  = 8'd0,
        REG_ECHO_TIMEOUT   = 8'd1,
        REG_REPEAT_GAP     = 8'd2,
        REG_DISTANCE_SCALE = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [TW_W-1:0]    trigger_width;
        logic [TICK_W-1:0]  echo_timeout;
        logic [GAP_W-1:0]   repeat_gap;
        logic [SCALE_W-1:0] distance_scale;
    } cfg_t;

    // one classified tick handed from front to back
    typedef struct packed {
        logic              trig;
        logic              finish;
        logic              timeout;
        logic [TICK_W-1:0] ticks;
    } rec_t;

endpackage

@@ sv/urmf_cfg.sv @@
// configuration register file
`timescale 1ns / 1ps

module urmf_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [urmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [urmf_pkg::CFG_DATA_W-1:0] cfg_data,
    output urmf_pkg::cfg_t                 cfg
);
    import urmf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always accepted and registered
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register decode, values masked to their widths
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TRIGGER_WIDTH:  cfg_next.trigger_width  = cfg_data[TW_W-1:0];
                REG_ECHO_TIMEOUT:   cfg_next.echo_timeout   = cfg_data[TICK_W-1:0];
                REG_REPEAT_GAP:     cfg_next.repeat_gap     = cfg_data[GAP_W-1:0];
                REG_DISTANCE_SCALE: cfg_next.distance_scale = cfg_data[SCALE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_width  <= TRIGGER_WIDTH_RST;
            cfg_reg.echo_timeout   <= ECHO_TIMEOUT_RST;
            cfg_reg.repeat_gap     <= REPEAT_GAP_RST;
            cfg_reg.distance_scale <= DISTANCE_SCALE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/urmf_front.sv @@
// measurement sequencer: classifies each tick and emits one record per word
`timescale 1ns / 1ps
`include "assert_macros.svh"

module urmf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  urmf_pkg::cfg_t    cfg,
    input  logic              accept,
    input  logic              echo_level,
    output logic              push,
    output urmf_pkg::rec_t    rec
);
    import urmf_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CNT_W-1:0]   tick_reg;
    logic [CNT_W-1:0]   tick_next;
    logic [TICK_W-1:0]  echo_reg;
    logic [TICK_W-1:0]  echo_next;

    logic [TW_W-1:0]    tw_eff;
    logic [TICK_W-1:0]  to_eff;
    logic [CNT_W-1:0]   cnt_inc;
    phase_t             done_phase;

    // zero width and zero timeout behave as one tick
    assign tw_eff     = (cfg.trigger_width == '0) ? TW_W'(1) : cfg.trigger_width;
    assign to_eff     = (cfg.echo_timeout == '0) ? TICK_W'(1) : cfg.echo_timeout;
    assign cnt_inc    = tick_reg + CNT_W'(1);
    assign done_phase = (cfg.repeat_gap == '0) ? PH_TRIG : PH_GAP;
    assign push       = accept;

    // next state and record for the accepted word
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        echo_next  = echo_reg;
        rec        = '0;
        if (accept) begin
            unique case (phase_reg)
                PH_TRIG: begin
                    rec.trig = 1'b1;
                    if (cnt_inc >= CNT_W'(tw_eff)) begin
                        tick_next  = '0;
                        echo_next  = '0;
                        phase_next = PH_WAIT;
                    end else begin
                        tick_next = cnt_inc;
                    end
                end
                PH_WAIT: begin
                    if (echo_level) begin
                        echo_next  = TICK_W'(1);
                        phase_next = PH_HIGH;
                    end else if (cnt_inc > CNT_W'(to_eff)) begin
                        rec.finish  = 1'b1;
                        rec.timeout = 1'b1;
                        tick_next   = '0;
                        phase_next  = done_phase;
                    end else begin
                        tick_next = cnt_inc;
                    end
                end
                PH_HIGH: begin
                    if (echo_level) begin
                        if (echo_reg >= to_eff) begin
                            rec.finish  = 1'b1;
                            rec.timeout = 1'b1;
                            tick_next   = '0;
                            phase_next  = done_phase;
                        end else begin
                            echo_next = echo_reg + TICK_W'(1);
                        end
                    end else begin
                        rec.finish = 1'b1;
                        rec.ticks  = echo_reg;
                        tick_next  = '0;
                        phase_next = done_phase;
                    end
                end
                PH_GAP: begin
                    if (cnt_inc >= CNT_W'(cfg.repeat_gap)) begin
                        tick_next  = '0;
                        phase_next = PH_TRIG;
                    end else begin
                        tick_next = cnt_inc;
                    end
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TRIG;
            tick_reg  <= '0;
            echo_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            echo_reg  <= echo_next;
        end
    end

    `URMF_ASSERT_IMP(a_high_nonzero, phase_reg == PH_HIGH, echo_reg != '0, "pulse count zero")
    `URMF_ASSERT_IMP(a_good_read, push && rec.finish && !rec.timeout, rec.ticks != '0, "empty reading")

endmodule

@@ sv/urmf_fifo.sv @@
// two-entry record queue between sequencer and arithmetic pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"

module urmf_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  urmf_pkg::rec_t push_rec,
    output logic           in_ready,
    input  logic           pop,
    output logic           out_valid,
    output urmf_pkg::rec_t out_rec
);
    import urmf_pkg::*;

    rec_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_reg;
    logic [FIFO_PTR_W-1:0] wr_next;
    logic [FIFO_PTR_W-1:0] rd_reg;
    logic [FIFO_PTR_W-1:0] rd_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;

    assign in_ready  = (cnt_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_rec   = mem_reg[rd_reg];

    // pointer and fill count update
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_reg + FIFO_PTR_W'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

    `URMF_ASSERT(a_fill_bound, cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH), "queue overfilled")

endmodule

@@ sv/urmf_back.sv @@
// distance scaling, median window and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module urmf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [urmf_pkg::SCALE_W-1:0]  distance_scale,
    input  logic                          rec_valid,
    input  urmf_pkg::rec_t                rec_in,
    output logic                          rec_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_trig_out,
    output logic                          m_reading_valid,
    output logic                          m_timed_out,
    output logic [urmf_pkg::DIST_W-1:0]   m_raw_distance,
    output logic [urmf_pkg::DIST_W-1:0]   m_median_distance
);
    import urmf_pkg::*;

    // stage 1: product
    logic              v1_reg;
    rec_t              rec1_reg;
    logic [PROD_W-1:0] prod1_reg;
    // stage 2: distance, window written
    logic              v2_reg;
    rec_t              rec2_reg;
    logic [DIST_W-1:0] dist2_reg;
    // stage 3: output register
    logic              v3_reg;
    logic              trig3_reg;
    logic              rv3_reg;
    logic              to3_reg;
    logic [DIST_W-1:0] raw3_reg;
    logic [DIST_W-1:0] filt3_reg;
    // filter state
    logic [DIST_W-1:0] win_reg [WIN_SIZE];
    logic [SLOT_W-1:0] slot_reg;
    logic [DIST_W-1:0] last_med_reg;

    logic              rdy1;
    logic              rdy2;
    logic              rdy3;
    logic              mv2;
    logic              mv3;
    logic [DIST_W-1:0] dist1;
    logic [DIST_W-1:0] med;
    logic [DIST_W-1:0] filt_next;

    // elastic stage handshake
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign rec_pop = rec_valid && rdy1;
    assign mv2     = v1_reg && rdy2;
    assign mv3     = v2_reg && rdy3;

    // scaled distance, zero when no reading completes
    assign dist1 = rec1_reg.finish ? prod1_reg[FRAC_W +: DIST_W] : '0;

    // median by stable rank: element whose rank is the middle one
    always_comb begin
        logic [RANK_W-1:0] rank [WIN_SIZE];
        med = '0;
        for (int i = 0; i < WIN_SIZE; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WIN_SIZE; j++) begin
                if (j < i) begin
                    rank[i] = rank[i] + RANK_W'(win_reg[j] <= win_reg[i]);
                end else if (j > i) begin
                    rank[i] = rank[i] + RANK_W'(win_reg[j] < win_reg[i]);
                end
            end
        end
        for (int i = 0; i < WIN_SIZE; i++) begin
            if (rank[i] == RANK_W'(MED_RANK)) begin
                med = win_reg[i];
            end
        end
    end

    assign filt_next = rec2_reg.finish ? med : last_med_reg;

    // stage valid bits and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            slot_reg     <= '0;
            last_med_reg <= '0;
            for (int i = 0; i < WIN_SIZE; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (rdy1) begin
                v1_reg <= rec_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (mv2 && rec1_reg.finish) begin
                win_reg[slot_reg] <= dist1;
                slot_reg <= (slot_reg == SLOT_W'(WIN_SIZE - 1)) ? '0
                                                                : slot_reg + SLOT_W'(1);
            end
            if (mv3) begin
                last_med_reg <= filt_next;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            rec1_reg  <= rec_in;
            prod1_reg <= PROD_W'(rec_in.ticks) * PROD_W'(distance_scale);
        end
        if (mv2) begin
            rec2_reg  <= rec1_reg;
            dist2_reg <= dist1;
        end
        if (mv3) begin
            trig3_reg <= rec2_reg.trig;
            rv3_reg   <= rec2_reg.finish;
            to3_reg   <= rec2_reg.timeout;
            raw3_reg  <= dist2_reg;
            filt3_reg <= filt_next;
        end
    end

    assign m_valid           = v3_reg;
    assign m_trig_out        = trig3_reg;
    assign m_reading_valid   = rv3_reg;
    assign m_timed_out       = to3_reg;
    assign m_raw_distance    = raw3_reg;
    assign m_median_distance = filt3_reg;

    `URMF_ASSERT(a_slot_range, slot_reg <= SLOT_W'(WIN_SIZE - 1), "window slot out of range")
    `URMF_ASSERT_IMP(a_idle_word, v3_reg && !rv3_reg, raw3_reg == '0 && !to3_reg, "stray reading")

endmodule

@@ sv/ultrasonic_range_median_filter.sv @@
// top level: echo ranging sequencer with median-of-window distance filter
// path: record queue, then product, distance and output registers, to the m_ side;
// throughput: one tick word per cycle while m_ready does not stall; the sequencer,
// queue and three-stage multiply / window / median pipeline each take one per cycle
// reset: synchronous active-low aresetn; sequencer restarts in the trigger phase,
// window, slot and last median clear to zero, registers return to their defaults
`timescale 1ns / 1ps

module ultrasonic_range_median_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [urmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [urmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_echo_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_trig_out,
    output logic                            m_reading_valid,
    output logic                            m_timed_out,
    output logic [urmf_pkg::DIST_W-1:0]     m_raw_distance,
    output logic [urmf_pkg::DIST_W-1:0]     m_median_distance
);
    import urmf_pkg::*;

    cfg_t cfg;
    rec_t front_rec;
    rec_t queue_rec;
    logic front_push;
    logic queue_valid;
    logic queue_pop;
    logic accept;

    assign accept = s_valid && s_ready;

    // configuration registers
    urmf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // measurement sequencer
    urmf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (accept),
        .echo_level (s_echo_level),
        .push       (front_push),
        .rec        (front_rec)
    );

    // record queue
    urmf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_rec  (front_rec),
        .in_ready  (s_ready),
        .pop       (queue_pop),
        .out_valid (queue_valid),
        .out_rec   (queue_rec)
    );

    // distance and median pipeline
    urmf_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .distance_scale    (cfg.distance_scale),
        .rec_valid         (queue_valid),
        .rec_in            (queue_rec),
        .rec_pop           (queue_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_trig_out        (m_trig_out),
        .m_reading_valid   (m_reading_valid),
        .m_timed_out       (m_timed_out),
        .m_raw_distance    (m_raw_distance),
        .m_median_distance (m_median_distance)
    );

endmodule

@@ tb/sv/ultrasonic_range_median_filter_tb.sv @@
// testbench for the ultrasonic ranging median filter: directed table, then random ticks
`timescale 1ns / 1ps

module ultrasonic_range_median_filter_tb;
    import urmf_pkg::*;

    // one result word as the block presents it
    typedef struct packed {
        logic              trig;
        logic              done;
        logic              tmo;
        logic [DIST_W-1:0] raw;
        logic [DIST_W-1:0] med;
    } reading_t;

    // one directed tick, with an optional typed-in result word
    typedef struct packed {
        logic     echo;
        logic     pinned;
        reading_t want;
    } tick_row_t;

    localparam int       NUM_REGS        = 4;
    localparam int       RANDOM_PHASES   = 12;
    localparam int       ITEMS_PER_PHASE = 115;
    localparam int       LONG_PHASE      = 6;
    localparam int       PRINT_LIMIT     = 100;
    localparam int       SETTINGS_ROW    = 3;
    localparam int       DIRECTED_ROWS   = 21;
    localparam int       PLAN_CAP        = 200;
    localparam int       LONG_HIGH_TICKS = 200;
    localparam logic [DIST_W-1:0] LONG_RAW_MIN = DIST_W'(800);
    localparam real      WATCHDOG_NS     = 5000000.0;

    localparam reading_t TRIG_WORD    = '{trig: 1'b1, done: 1'b0, tmo: 1'b0, raw: '0, med: '0};
    localparam reading_t TIMEOUT_WORD = '{trig: 1'b0, done: 1'b1, tmo: 1'b1, raw: '0, med: '0};
    localparam reading_t NO_WORD      = '0;

    // after reset: trigger ticks; then zero width / zero timeout / zero gap / max scale
    localparam tick_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 1'b1, TRIG_WORD},
        '{1'b1, 1'b1, TRIG_WORD},
        '{1'b0, 1'b1, TRIG_WORD},
        '{1'b0, 1'b1, TRIG_WORD},
        '{1'b0, 1'b0, NO_WORD},
        '{1'b0, 1'b1, TIMEOUT_WORD},
        '{1'b1, 1'b0, NO_WORD},
        '{1'b1, 1'b0, NO_WORD},
        '{1'b0, 1'b0, NO_WORD},
        '{1'b0, 1'b0, NO_WORD},
        '{1'b1, 1'b0, NO_WORD},
        '{1'b1, 1'b0, NO_WORD},
        '{1'b1, 1'b0, NO_WORD},
        '{1'b1, 1'b0, NO_WORD},
        '{1'b0, 1'b0, NO_WORD},
        '{1'b0, 1'b0, NO_WORD},
        '{1'b1, 1'b0, NO_WORD},
        '{1'b0, 1'b0, NO_WORD},
        '{1'b0, 1'b0, NO_WORD},
        '{1'b1, 1'b0, NO_WORD},
        '{1'b0, 1'b0, NO_WORD}
    };

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_echo_level = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic                  m_trig_out;
    logic                  m_reading_valid;
    logic                  m_timed_out;
    logic [DIST_W-1:0]     m_raw_distance;
    logic [DIST_W-1:0]     m_median_distance;

    // register copies
    logic [TW_W-1:0]    set_trig_width = TRIGGER_WIDTH_RST;
    logic [TICK_W-1:0]  set_timeout    = ECHO_TIMEOUT_RST;
    logic [GAP_W-1:0]   set_gap        = REPEAT_GAP_RST;
    logic [SCALE_W-1:0] set_scale      = DISTANCE_SCALE_RST;

    // ranging state
    phase_t            rng_phase  = PH_TRIG;
    logic [CNT_W-1:0]  rng_ticks  = '0;
    logic [TICK_W-1:0] rng_echo   = '0;
    logic [DIST_W-1:0] rng_window [WIN_SIZE] = '{default: '0};
    int                rng_slot   = 0;
    logic [DIST_W-1:0] rng_median = '0;

    reading_t expected_readings [$];
    int       err_count  = 0;
    int       tx_rate    = 0;
    int       rx_rate    = 0;
    int       stall_left = 0;
    int       plan_wait  = 0;
    int       plan_high  = 0;
    bit       long_pulse = 1'b0;

    ultrasonic_range_median_filter dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_echo_level      (s_echo_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_trig_out        (m_trig_out),
        .m_reading_valid   (m_reading_valid),
        .m_timed_out       (m_timed_out),
        .m_raw_distance    (m_raw_distance),
        .m_median_distance (m_median_distance)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // close a reading: store the distance in the ring and take the median
    function automatic reading_t finish_range(input logic tmo, input logic [TICK_W-1:0] ticks);
        reading_t          word;
        logic [PROD_W-1:0] prod;
        logic [DIST_W-1:0] sorted [WIN_SIZE];
        logic [DIST_W-1:0] v;
        int                i;
        int                j;
        prod = PROD_W'(ticks) * PROD_W'(set_scale);
        word = '0;
        word.done = 1'b1;
        word.tmo  = tmo;
        word.raw  = tmo ? '0 : DIST_W'(prod >> FRAC_W);
        rng_window[rng_slot] = word.raw;
        rng_slot = (rng_slot + 1) % WIN_SIZE;
        for (i = 0; i < WIN_SIZE; i++)
            sorted[i] = rng_window[i];
        // insertion sort, ascending
        for (i = 1; i < WIN_SIZE; i++) begin
            v = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > v) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = v;
        end
        rng_median = sorted[MED_RANK];
        word.med   = rng_median;
        rng_ticks  = '0;
        rng_phase  = (set_gap == '0) ? PH_TRIG : PH_GAP;
        return word;
    endfunction

    // advance the ranging sequencer by one tick and return the word it yields
    function automatic reading_t step_ranging(input logic echo);
        reading_t          word;
        logic [TW_W-1:0]   tw_eff;
        logic [TICK_W-1:0] to_eff;
        tw_eff = (set_trig_width == '0) ? TW_W'(1) : set_trig_width;
        to_eff = (set_timeout == '0) ? TICK_W'(1) : set_timeout;
        word = '0;
        word.med = rng_median;
        case (rng_phase)
            PH_WAIT: begin
                if (echo) begin
                    rng_echo  = TICK_W'(1);
                    rng_phase = PH_HIGH;
                end else begin
                    rng_ticks = rng_ticks + 1'b1;
                    if (rng_ticks > CNT_W'(to_eff))
                        word = finish_range(1'b1, '0);
                end
            end
            PH_HIGH: begin
                if (!echo)
                    word = finish_range(1'b0, rng_echo);
                else if (rng_echo >= to_eff)
                    word = finish_range(1'b1, '0);
                else
                    rng_echo = rng_echo + 1'b1;
            end
            PH_GAP: begin
                rng_ticks = rng_ticks + 1'b1;
                if (rng_ticks >= set_gap) begin
                    rng_ticks = '0;
                    rng_phase = PH_TRIG;
                end
            end
            default: begin
                word.trig = 1'b1;
                rng_ticks = rng_ticks + 1'b1;
                if (rng_ticks >= CNT_W'(tw_eff)) begin
                    rng_ticks = '0;
                    rng_echo  = '0;
                    rng_phase = PH_WAIT;
                end
            end
        endcase
        return word;
    endfunction

    // echo level for the next tick: a planned pulse per measurement, plus some noise
    function automatic logic choose_echo();
        logic lvl;
        int   lim;
        lim = (set_timeout == '0) ? 1 : ((set_timeout > PLAN_CAP) ? PLAN_CAP : int'(set_timeout));
        case (rng_phase)
            PH_WAIT: begin
                lvl = (plan_wait == 0);
                if (plan_wait != 0)
                    plan_wait--;
            end
            PH_HIGH: begin
                lvl = (plan_high != 0);
                if (plan_high != 0)
                    plan_high--;
            end
            default: begin
                if (long_pulse) begin
                    plan_wait = 0;
                    plan_high = LONG_HIGH_TICKS;
                end else begin
                    plan_wait = $urandom_range(0, lim + 2);
                    plan_high = $urandom_range(0, lim + 1);
                end
                lvl = ($urandom_range(0, 7) == 0);
            end
        endcase
        if (!long_pulse && $urandom_range(0, 39) == 0)
            lvl = ~lvl;
        return lvl;
    endfunction

    // random upper bits above the register width, half of the time
    function automatic logic [CFG_DATA_W-1:0] pad_bits(input logic [CFG_DATA_W-1:0] v,
                                                       input int w);
        logic [CFG_DATA_W-1:0] hi;
        hi = $urandom() << w;
        return ($urandom_range(0, 1) == 1) ? (v | hi) : v;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // one register write; the caller drops cfg_valid after the last of a run
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TRIGGER_WIDTH:  set_trig_width = data[TW_W-1:0];
            REG_ECHO_TIMEOUT:   set_timeout    = data[TICK_W-1:0];
            REG_REPEAT_GAP:     set_gap        = data[GAP_W-1:0];
            REG_DISTANCE_SCALE: set_scale      = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int tw, input int to, input int gap, input int sc);
        write_setting(REG_TRIGGER_WIDTH, pad_bits(tw, TW_W));
        write_setting(REG_ECHO_TIMEOUT, pad_bits(to, TICK_W));
        write_setting(REG_REPEAT_GAP, pad_bits(gap, GAP_W));
        write_setting(REG_DISTANCE_SCALE, pad_bits(sc, SCALE_W));
        // an index past the register list must change nothing
        write_setting(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    // present one tick word and hold it until accepted
    task automatic push_tick(input logic echo, input logic pinned, input reading_t pinned_word,
                             output reading_t word);
        s_valid      <= 1'b1;
        s_echo_level <= echo;
        do @(posedge aclk); while (!s_ready);
        word = step_ranging(echo);
        if (pinned)
            word = pinned_word;
        expected_readings.push_back(word);
    endtask

    task automatic idle_burst();
        s_valid      <= 1'b0;
        s_echo_level <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 12)) @(posedge aclk);
    endtask

    // sender holds off until every expected word has come back
    task automatic drain_readings();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge aclk);
    endtask

    // receiver stalls in bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_rate != 0 && $urandom_range(0, rx_rate) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted word with the oldest expected reading
    always @(posedge aclk) begin : check_words
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("word with no reading expected");
            end else begin
                want = expected_readings.pop_front();
                if (m_trig_out !== want.trig)
                    report_mismatch($sformatf("trig_out got %0d expected %0d",
                                              m_trig_out, want.trig));
                if (m_reading_valid !== want.done)
                    report_mismatch($sformatf("reading_valid got %0d expected %0d",
                                              m_reading_valid, want.done));
                if (m_timed_out !== want.tmo)
                    report_mismatch($sformatf("timed_out got %0d expected %0d",
                                              m_timed_out, want.tmo));
                if (m_raw_distance !== want.raw)
                    report_mismatch($sformatf("raw_distance got %0d expected %0d",
                                              m_raw_distance, want.raw));
                if (m_median_distance !== want.med)
                    report_mismatch($sformatf("median_distance got %0d expected %0d",
                                              m_median_distance, want.med));
            end
        end
    end

    // stimulus
    initial begin : stimulus
        reading_t word;
        int       i;
        int       ph;
        int       n;
        int       tw_v;
        int       to_v;
        int       gap_v;
        int       sc_v;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (i == SETTINGS_ROW) begin
                drain_readings();
                write_setting(REG_TRIGGER_WIDTH, 32'hFFFF_FC00);
                write_setting(REG_ECHO_TIMEOUT, 32'hFFFF_0000);
                write_setting(REG_REPEAT_GAP, 32'hFFF0_0000);
                write_setting(REG_DISTANCE_SCALE, 32'hFFFF_FFFF);
                write_setting(CFG_IDX_W'(255), 32'hFFFF_FFFF);
                cfg_valid <= 1'b0;
            end
            push_tick(DIRECTED[i].echo, DIRECTED[i].pinned, DIRECTED[i].want, word);
        end

        // random phases, each under its own settings
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_readings();
            if (ph == LONG_PHASE) begin
                // one long pulse at the largest timeout and the largest scale
                tx_rate    = 0;
                rx_rate    = 0;
                long_pulse = 1'b1;
                apply_settings(1, 65535, 0, 262143);
                do push_tick(choose_echo(), 1'b0, NO_WORD, word);
                while (!(word.done && !word.tmo && word.raw > LONG_RAW_MIN));
                long_pulse = 1'b0;
                drain_readings();
            end
            case (ph)
                0: begin
                    tw_v = 1023; to_v = 65535; gap_v = 1048575; sc_v = 262143;
                end
                1: begin
                    tw_v = 0; to_v = 0; gap_v = 0; sc_v = 0;
                end
                default: begin
                    tw_v  = $urandom_range(0, 4);
                    to_v  = $urandom_range(0, 30);
                    gap_v = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 60)
                                                        : $urandom_range(0, 6);
                    sc_v  = $urandom_range(0, 262143);
                end
            endcase
            apply_settings(tw_v, to_v, gap_v, sc_v);
            if (ph >= RANDOM_PHASES - 2) begin
                tx_rate = 0;
                rx_rate = 0;
            end else begin
                tx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
                rx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (tx_rate != 0 && $urandom_range(0, tx_rate) == 0)
                    idle_burst();
                push_tick(choose_echo(), 1'b0, NO_WORD, word);
            end
        end

        // wind down
        drain_readings();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("%0t ns: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
